// ----- rtl/sspsq_pkg.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// sspsq_pkg
// Shared types and constants of the servo slew and power sequencer.
// ----------------------------------------------------------------------------
package sspsq_pkg;

   // Widths of the payload fields.
   localparam int unsigned PosWidth   = 8;
   localparam int unsigned CountWidth = 8;
   localparam int unsigned CsrIdxWidth = 3;

   typedef logic [PosWidth-1:0]    pos_type;
   typedef logic [CountWidth-1:0]  count_type;
   typedef logic [CsrIdxWidth-1:0] csr_idx_type;

   // Register indexes of the configuration port.
   typedef enum logic [CsrIdxWidth-1:0] {
      CSR_CLOSED_POS  = 3'd0,
      CSR_THROWN_POS  = 3'd1,
      CSR_STEP_SIZE   = 3'd2,
      CSR_HOLD_TICKS  = 3'd3,
      CSR_OFF_TICKS   = 3'd4,
      CSR_REFRESH_TICKS = 3'd5
   } csr_index_type;

   // Function codes of a request.
   localparam logic FUNC_TICK    = 1'b0;
   localparam logic FUNC_SET_DIR = 1'b1;

   // Direction codes.
   localparam logic DIR_CLOSED = 1'b0;
   localparam logic DIR_THROWN = 1'b1;

   // Register reset values.
   localparam pos_type   ClosedPosReset    = 8'd0;
   localparam pos_type   ThrownPosReset    = 8'd0;
   localparam pos_type   StepSizeReset     = 8'd1;
   localparam count_type HoldTicksReset    = 8'd20;
   localparam count_type OffTicksReset     = 8'd100;
   localparam count_type RefreshTicksReset = 8'd10;

   // Configuration seen by the sequencer core.
   typedef struct packed {
      pos_type   closed_position;
      pos_type   thrown_position;
      pos_type   step_size;
      count_type hold_ticks;
      count_type off_ticks;
      count_type refresh_ticks;
   } cfg_type;

endpackage : sspsq_pkg
`default_nettype wire

// ----- rtl/sspsq_if.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// sspsq_if
// Valid/ready channels of the sequencer: request, response and register write.
// ----------------------------------------------------------------------------
interface sspsq_req_if;
   logic valid;
   logic ready;
   logic func;
   logic direction;

   modport source (output valid, output func, output direction, input ready);
   modport sink   (input valid, input func, input direction, output ready);
endinterface : sspsq_req_if

interface sspsq_rsp_if;
   logic                  valid;
   logic                  ready;
   sspsq_pkg::pos_type    position;
   logic                  pulse_enable;
   logic                  power_enable;
   logic                  at_target;

   modport source (output valid, output position, output pulse_enable,
                   output power_enable, output at_target, input ready);
   modport sink   (input valid, input position, input pulse_enable,
                   input power_enable, input at_target, output ready);
endinterface : sspsq_rsp_if

interface sspsq_csr_if;
   logic                   valid;
   logic                   ready;
   sspsq_pkg::csr_idx_type index;
   sspsq_pkg::pos_type     data;

   modport source (output valid, output index, output data, input ready);
   modport sink   (input valid, input index, input data, output ready);
endinterface : sspsq_csr_if
`default_nettype wire

// ----- rtl/sspsq_csr.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// sspsq_csr
// Configuration register file; a write with an unknown index is dropped.
// ----------------------------------------------------------------------------
module sspsq_csr (
   input  wire logic               clock,
   input  wire logic               reset,
   sspsq_csr_if.sink               csr_ch,
   output sspsq_pkg::cfg_type      cfg
);
   import sspsq_pkg::*;

   cfg_type cfg_ff;
   cfg_type cfg_in;
   logic    wr_en;

   // Writes are always taken.
   assign csr_ch.ready = 1'b1;
   assign wr_en        = csr_ch.valid;

   // Decode the write transaction.
   always_comb begin
      cfg_in = cfg_ff;
      if (wr_en) begin
         case (csr_ch.index)
            CSR_CLOSED_POS:    cfg_in.closed_position = csr_ch.data;
            CSR_THROWN_POS:    cfg_in.thrown_position = csr_ch.data;
            CSR_STEP_SIZE:     cfg_in.step_size       = csr_ch.data;
            CSR_HOLD_TICKS:    cfg_in.hold_ticks      = csr_ch.data;
            CSR_OFF_TICKS:     cfg_in.off_ticks       = csr_ch.data;
            CSR_REFRESH_TICKS: cfg_in.refresh_ticks   = csr_ch.data;
            default:           cfg_in = cfg_ff;
         endcase
      end
   end

   // Register storage with documented reset values.
   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.closed_position <= ClosedPosReset;
         cfg_ff.thrown_position <= ThrownPosReset;
         cfg_ff.step_size       <= StepSizeReset;
         cfg_ff.hold_ticks      <= HoldTicksReset;
         cfg_ff.off_ticks       <= OffTicksReset;
         cfg_ff.refresh_ticks   <= RefreshTicksReset;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule : sspsq_csr
`default_nettype wire

// ----- rtl/sspsq_core.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// sspsq_core
// Position slew and power phase update, with the response register.
// ----------------------------------------------------------------------------
module sspsq_core (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire sspsq_pkg::cfg_type cfg,
   sspsq_req_if.sink               req_ch,
   sspsq_rsp_if.source             rsp_ch
);
   import sspsq_pkg::*;

   typedef enum logic [1:0] {
      PH_MOVE    = 2'd0,
      PH_HOLD    = 2'd1,
      PH_WAIT    = 2'd2,
      PH_REFRESH = 2'd3
   } phase_type;

   // Sequencer state.
   pos_type   position_ff, position_in;
   logic      target_sel_ff, target_sel_in;
   phase_type phase_ff, phase_in;
   count_type count_ff, count_in;
   logic      pulse_ff, pulse_in;

   // Response register.
   logic      rsp_valid_ff, rsp_valid_in;
   pos_type   rsp_position_ff;
   logic      rsp_pulse_ff;
   logic      rsp_power_ff;
   logic      rsp_at_target_ff;

   logic      accept;
   pos_type   goal;
   pos_type   goal_next;
   logic [PosWidth:0] step_sum;
   logic [PosWidth:0] step_diff;
   pos_type   slew_pos;
   count_type count_inc;
   count_type limit;
   logic      count_done;

   // A new transaction is taken whenever the response slot frees up.
   assign req_ch.ready = !rsp_valid_ff || rsp_ch.ready;
   assign accept       = req_ch.valid && req_ch.ready;

   assign goal = target_sel_ff ? cfg.thrown_position : cfg.closed_position;

   // Step toward the goal on a 9-bit sum or difference, then clamp.
   assign step_sum  = {1'b0, position_ff} + {1'b0, cfg.step_size};
   assign step_diff = {1'b0, position_ff} - {1'b0, cfg.step_size};
   always_comb begin
      if (position_ff < goal) begin
         slew_pos = (step_sum > {1'b0, goal}) ? goal : step_sum[PosWidth-1:0];
      end else begin
         slew_pos = (step_diff[PosWidth] || (step_diff[PosWidth-1:0] < goal)) ?
                    goal : step_diff[PosWidth-1:0];
      end
   end

   // Phase counter, wrapping at eight bits.
   always_comb begin
      case (phase_ff)
         PH_HOLD: limit = cfg.hold_ticks;
         PH_WAIT: limit = cfg.off_ticks;
         default: limit = cfg.refresh_ticks;
      endcase
   end
   assign count_inc  = count_ff + 8'd1;
   assign count_done = (count_inc == limit);

   // Next state for one request.
   always_comb begin
      position_in   = position_ff;
      target_sel_in = target_sel_ff;
      phase_in      = phase_ff;
      count_in      = count_ff;
      pulse_in      = pulse_ff;
      if (accept) begin
         if (req_ch.func == FUNC_SET_DIR) begin
            target_sel_in = req_ch.direction;
         end else if (position_ff != goal) begin
            phase_in    = PH_MOVE;
            pulse_in    = 1'b1;
            position_in = slew_pos;
         end else begin
            case (phase_ff)
               PH_MOVE: begin
                  phase_in = PH_HOLD;
                  count_in = '0;
               end
               PH_HOLD, PH_REFRESH: begin
                  count_in = count_done ? '0 : count_inc;
                  if (count_done) begin
                     phase_in = PH_WAIT;
                     pulse_in = 1'b0;
                  end
               end
               PH_WAIT: begin
                  count_in = count_done ? '0 : count_inc;
                  if (count_done) begin
                     phase_in = PH_REFRESH;
                     pulse_in = 1'b1;
                  end
               end
               default: phase_in = phase_ff;
            endcase
         end
      end
   end

   // Target after the update, for the at-target flag.
   assign goal_next = target_sel_in ? cfg.thrown_position : cfg.closed_position;

   // Response slot occupancy.
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (accept) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ch.ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   // Control state.
   always_ff @(posedge clock) begin
      if (reset) begin
         position_ff   <= '0;
         target_sel_ff <= DIR_THROWN;
         phase_ff      <= PH_MOVE;
         count_ff      <= '0;
         pulse_ff      <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         position_ff   <= position_in;
         target_sel_ff <= target_sel_in;
         phase_ff      <= phase_in;
         count_ff      <= count_in;
         pulse_ff      <= pulse_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   // Response payload, loaded on each accepted request.
   always_ff @(posedge clock) begin
      if (accept) begin
         rsp_position_ff  <= position_in;
         rsp_pulse_ff     <= pulse_in;
         rsp_power_ff     <= (phase_in != PH_WAIT);
         rsp_at_target_ff <= (position_in == goal_next);
      end
   end

   assign rsp_ch.valid        = rsp_valid_ff;
   assign rsp_ch.position     = rsp_position_ff;
   assign rsp_ch.pulse_enable = rsp_pulse_ff;
   assign rsp_ch.power_enable = rsp_power_ff;
   assign rsp_ch.at_target    = rsp_at_target_ff;

endmodule : sspsq_core
`default_nettype wire

// ----- rtl/servo_slew_and_power_sequencer_unit.sv -----
// A response is valid in the cycle after its request transaction.
// Throughput: one request per cycle; the single response register refills in
// the same cycle that its transaction is taken, and a held-off response stalls
// the request side until it is taken.
// Reset (synchronous, active high): position 0, thrown target selected, move
// phase, pulses detached, registers at their defaults, response slot empty.
`default_nettype none
// ----------------------------------------------------------------------------
// servo_slew_and_power_sequencer_unit
// Top level: configuration registers and the slew and power sequencer core.
// ----------------------------------------------------------------------------
module servo_slew_and_power_sequencer_unit (
   input  wire logic    clock,
   input  wire logic    reset,
   sspsq_req_if.sink    req_ch,
   sspsq_rsp_if.source  rsp_ch,
   sspsq_csr_if.sink    csr_ch
);
   import sspsq_pkg::*;

   cfg_type cfg;

   // Configuration registers.
   sspsq_csr u_csr (
      .clock  (clock),
      .reset  (reset),
      .csr_ch (csr_ch),
      .cfg    (cfg)
   );

   // Sequencer core with response register.
   sspsq_core u_core (
      .clock  (clock),
      .reset  (reset),
      .cfg    (cfg),
      .req_ch (req_ch),
      .rsp_ch (rsp_ch)
   );

endmodule : servo_slew_and_power_sequencer_unit
`default_nettype wire
